/* rtl/core/rmid_pkg.sv */
package rmid_pkg;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2
   } rmid_status_type;

   localparam int OUT_DATA_WIDTH  = 16;
   localparam int OUT_COUNT_WIDTH = 7;
   localparam int IN_VALUE_WIDTH  = 16;

   // update strobes broadcast to every cell
   typedef struct packed {
      logic ins_en;
      logic del_en;
   } rmid_ctl_type;

endpackage

/* rtl/core/rmid_cell.sv */
module rmid_cell
   import rmid_pkg::*;
#(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  rmid_ctl_type                 ctl,
   input  logic signed [DATA_WIDTH-1:0] value,
   input  logic signed [DATA_WIDTH-1:0] left_data,
   input  logic signed [DATA_WIDTH-1:0] right_data,
   input  logic                         left_gt,
   input  logic                         occupied,
   output logic signed [DATA_WIDTH-1:0] data_ff,
   output logic                         gt,
   output logic                         eq
);

   logic signed [DATA_WIDTH-1:0] data_in;
   logic                         ge;

   // empty cells act as larger than any value
   assign gt = !occupied || (data_ff > value);
   assign ge = !occupied || (data_ff >= value);
   assign eq = occupied && (data_ff == value);

   always_comb begin
      priority if (ctl.ins_en) begin
         priority if (left_gt) begin
            data_in = left_data;
         end else if (gt) begin
            data_in = value;
         end else begin
            data_in = data_ff;
         end
      end else if (ctl.del_en) begin
         data_in = ge ? right_data : data_ff;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* rtl/core/rmid_median.sv */
module rmid_median
   import rmid_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [DATA_WIDTH-1:0]        store [CAPACITY],
   input  logic [$clog2(CAPACITY+1)-1:0]       count,
   output logic signed [DATA_WIDTH-1:0]        median,
   output logic                                has_median
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic [CW-1:0]                lo_cnt;
   logic [IW-1:0]                lo_idx;
   logic [IW-1:0]                hi_idx;
   logic signed [DATA_WIDTH-1:0] lo_ff;
   logic signed [DATA_WIDTH-1:0] hi_ff;
   logic                         odd_ff;
   logic                         empty_ff;
   logic signed [DATA_WIDTH:0]   sum;
   logic signed [DATA_WIDTH:0]   adj;

   assign lo_cnt = (count - CW'(1)) >> 1;
   assign lo_idx = lo_cnt[IW-1:0];
   assign hi_idx = lo_idx + IW'(1);

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff    <= store[lo_idx];
         hi_ff    <= store[hi_idx];
         odd_ff   <= count[0];
         empty_ff <= (count == '0);
      end
   end

   // halve toward zero
   assign sum = {lo_ff[DATA_WIDTH-1], lo_ff} + {hi_ff[DATA_WIDTH-1], hi_ff};
   assign adj = sum + {{DATA_WIDTH{1'b0}}, sum[DATA_WIDTH]};

   always_comb begin
      priority if (empty_ff) begin
         median = '0;
      end else if (odd_ff) begin
         median = lo_ff;
      end else begin
         median = adj[DATA_WIDTH:1];
      end
   end

   assign has_median = !empty_ff;

endmodule

/* rtl/core/running_median_insert_delete_core.sv */
// running median over a sorted multiset with insert and delete
//
// req channel: one word per operation, req_tuser = cmd (0 insert, 1 delete),
// req_tdata = value. rsp channel: one word per operation with status and
// has_median in rsp_tuser, median and count in rsp_tdata.
// the store is a row of CAPACITY cells, each holding one sorted entry; all
// cells compare the broadcast value at once and shift toward their neighbor
// in the cycle the word is taken, so the update time does not depend on the
// count. the S_SEL state then registers the middle entries, and the S_SUM
// state forms the median and loads it into the output register. a new
// operation is taken only once the last one's update/select/sum steps end.
// req_tready is high only while no operation is in flight.
// the result sits in an output register; a new request may be taken while it
// waits, and that request finishes once the receiver takes the old word.
// reset empties the store (count to zero) at once; no clearing pass.
module running_median_insert_delete_core
   import rmid_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value[15:0]
   input  logic        req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // median[15:0], count[22:16], zero[23]
   output logic [2:0]  rsp_tuser    // status[1:0], has_median[2]
);

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEL,
      S_SUM
   } state_type;

   state_type                    state_ff;
   state_type                    state_in;
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   rmid_status_type              status_ff;
   rmid_status_type              status_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   rmid_status_type              rsp_status_ff;
   logic [OUT_DATA_WIDTH-1:0]    rsp_median_ff;
   logic                         rsp_has_ff;
   logic [OUT_COUNT_WIDTH-1:0]   rsp_count_ff;

   logic                         accept;
   logic                         full;
   logic                         found;
   logic                         rsp_load;
   rmid_ctl_type                 ctl;
   logic [DATA_WIDTH+IN_VALUE_WIDTH-1:0]   value_ext;
   logic signed [DATA_WIDTH-1:0] value;
   logic signed [DATA_WIDTH-1:0] store [CAPACITY];
   logic [CAPACITY-1:0]          gt;
   logic [CAPACITY-1:0]          eq;
   logic signed [DATA_WIDTH-1:0] median;
   logic                         has_median;
   logic [DATA_WIDTH+OUT_DATA_WIDTH-1:0]   median_ext;
   logic [CW+OUT_COUNT_WIDTH-1:0]          count_ext;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign value_ext  = {{DATA_WIDTH{1'b0}}, req_tdata};
   assign value      = value_ext[DATA_WIDTH-1:0];
   assign full       = (count_ff >= CW'(CAPACITY));
   assign found      = |eq;

   assign ctl.ins_en = accept && (req_tuser == CMD_INSERT) && !full;
   assign ctl.del_en = accept && (req_tuser == CMD_DELETE) && found;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] left_data;
      logic signed [DATA_WIDTH-1:0] right_data;
      logic                         left_gt;
      logic                         occupied;

      if (i == 0) begin : g_first
         assign left_data = store[i];
         assign left_gt   = 1'b0;
      end else begin : g_mid
         assign left_data = store[i-1];
         assign left_gt   = gt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = store[i];
      end else begin : g_inner
         assign right_data = store[i+1];
      end
      assign occupied = (CW'(i) < count_ff);

      rmid_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .value      (value),
         .left_data  (left_data),
         .right_data (right_data),
         .left_gt    (left_gt),
         .occupied   (occupied),
         .data_ff    (store[i]),
         .gt         (gt[i]),
         .eq         (eq[i])
      );
   end

   rmid_median #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_median (
      .clock      (clock),
      .load       (state_ff == S_SEL),
      .store      (store),
      .count      (count_ff),
      .median     (median),
      .has_median (has_median)
   );

   assign median_ext = {{OUT_DATA_WIDTH{1'b0}}, median};
   assign count_ext  = {{OUT_COUNT_WIDTH{1'b0}}, count_ff};
   assign rsp_load   = (state_ff == S_SUM) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SEL;
               priority if (ctl.ins_en) begin
                  count_in  = count_ff + CW'(1);
                  status_in = ST_DONE;
               end else if (ctl.del_en) begin
                  count_in  = count_ff - CW'(1);
                  status_in = ST_DONE;
               end else if (req_tuser == CMD_INSERT) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_ABSENT;
               end
            end
         end
         S_SEL: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            if (rsp_load) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_median_ff <= median_ext[OUT_DATA_WIDTH-1:0];
         rsp_has_ff    <= has_median;
         rsp_count_ff  <= count_ext[OUT_COUNT_WIDTH-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_median_ff};
   assign rsp_tuser  = {rsp_has_ff, rsp_status_ff};

endmodule

/* rtl/core/rmid_checker.sv */
module rmid_checker
   import rmid_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   localparam logic [OUT_COUNT_WIDTH-1:0] CAP_FIELD = OUT_COUNT_WIDTH'(CAPACITY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> (rsp_tdata[15:0] == 16'd0)
         && (rsp_tuser[1:0] != ST_FULL))
      else $error("empty store gave nonzero median or full status");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == ST_FULL) |-> (rsp_tdata[22:16] == CAP_FIELD))
      else $error("full status with count below capacity");

   a_has_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (CAPACITY < 128) |-> (rsp_tuser[2] == (rsp_tdata[22:16] != 7'd0)))
      else $error("has_median disagrees with count");

endmodule

bind running_median_insert_delete_core rmid_checker #(
   .CAPACITY (CAPACITY)
) u_rmid_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
